### rtl/idf_pkg.sv
// Shared types, constants and packet-format lookups for the IMU packet deframer.
`default_nettype none

package idf_pkg;

	// APB register map: 32-bit registers, byte address 4*index
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned REG_IDX_W  = APB_ADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;

	// Output buffer holds two results
	localparam int unsigned OB_DEPTH = 2;

	typedef logic [1:0] mode_t;

	typedef struct packed {
		logic [31:0] word_value;
		logic [4:0]  word_index;
		logic        is_status;
		logic        checksum_ok;
	} result_t;

	function automatic logic [7:0] hdr_of(input mode_t m);
		logic [7:0] h;
		unique case (m)
			2'd0: h = 8'hCF;
			2'd1: h = 8'hD2;
			2'd2: h = 8'hC8;
			2'd3: h = 8'hCC;
			default: h = 8'hCF;
		endcase
		return h;
	endfunction

	function automatic logic [4:0] words_of(input mode_t m);
		logic [4:0] n;
		unique case (m)
			2'd0: n = 5'd6;
			2'd1: n = 5'd9;
			2'd2: n = 5'd15;
			2'd3: n = 5'd18;
			default: n = 5'd6;
		endcase
		return n;
	endfunction

	// Total packet length in bytes: header, words, 4 timer bytes, 2 checksum bytes
	function automatic logic [6:0] size_of(input mode_t m);
		logic [6:0] s;
		unique case (m)
			2'd0: s = 7'd31;
			2'd1: s = 7'd43;
			2'd2: s = 7'd67;
			2'd3: s = 7'd79;
			default: s = 7'd31;
		endcase
		return s;
	endfunction

	// First position past the data words
	function automatic logic [6:0] data_end_of(input mode_t m);
		return 7'd1 + {words_of(m), 2'b00};
	endfunction

	// Position of the checksum high byte
	function automatic logic [6:0] chk_pos_of(input mode_t m);
		return size_of(m) - 7'd2;
	endfunction

endpackage

`default_nettype wire

### rtl/idf_if.sv
// Valid/ready channel interfaces for received bytes and deframer results.
`default_nettype none

interface idf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface idf_result_if;
	logic        valid;
	logic        ready;
	logic [31:0] word_value;
	logic [4:0]  word_index;
	logic        is_status;
	logic        checksum_ok;

	modport source (output valid, output word_value, output word_index,
		output is_status, output checksum_ok, input ready);
	modport sink (input valid, input word_value, input word_index,
		input is_status, input checksum_ok, output ready);
endinterface

`default_nettype wire

### rtl/idf_cfg_regs.sv
// APB configuration register block holding the packet mode.
`default_nettype none

module idf_cfg_regs import idf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	output mode_t                      mode,
	output logic                       cfg_clear
);

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	mode_t                mode_q;

	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;

	// A mode write also restarts the framer
	assign cfg_clear = wr_en && (reg_idx == REG_MODE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 2'd0;
		end else if (cfg_clear) begin
			mode_q <= pwdata[1:0];
		end
	end

	assign mode = mode_q;

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_MODE) begin
			prdata = {{(APB_DATA_W-2){1'b0}}, mode_q};
		end
	end

endmodule

`default_nettype wire

### rtl/idf_framer.sv
// Input byte register and single-pass packet framing logic.
`default_nettype none

module idf_framer import idf_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	idf_byte_if.sink        rx,
	input  wire mode_t      mode,
	input  wire logic       cfg_clear,
	input  wire logic [1:0] buf_avail,
	output logic            res_valid,
	output result_t         res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;

	logic        in_pkt_q, in_pkt_d;
	logic [6:0]  pos_q, pos_d;
	logic [15:0] sum_q, sum_d;
	logic [23:0] shift_q, shift_d;
	logic [7:0]  sumhi_q, sumhi_d;

	logic [6:0]  word_pos;
	logic [6:0]  chk_pos;
	logic [6:0]  data_end;

	// Take a byte only if the output buffer has room for it and the one in flight
	assign rx.ready = buf_avail > {1'b0, valid_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cfg_clear) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= rx.valid && rx.ready;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	assign word_pos = pos_q - 7'd1;
	assign chk_pos  = chk_pos_of(mode);
	assign data_end = data_end_of(mode);

	always_comb begin
		in_pkt_d  = in_pkt_q;
		pos_d     = pos_q;
		sum_d     = sum_q;
		shift_d   = shift_q;
		sumhi_d   = sumhi_q;
		res_valid = 1'b0;
		res       = '0;
		if (valid_s1) begin
			if (!in_pkt_q) begin
				if (byte_s1 == hdr_of(mode)) begin
					in_pkt_d = 1'b1;
					pos_d    = 7'd1;
					sum_d    = {8'h00, byte_s1};
					shift_d  = '0;
					sumhi_d  = '0;
				end
			end else begin
				pos_d = pos_q + 7'd1;
				if (pos_q < chk_pos) begin
					sum_d = sum_q + {8'h00, byte_s1};
					if (pos_q < data_end) begin
						if (word_pos[1:0] == 2'b11) begin
							res_valid       = 1'b1;
							res.word_value  = {shift_q, byte_s1};
							res.word_index  = word_pos[6:2];
							shift_d         = '0;
						end else begin
							shift_d = {shift_q[15:0], byte_s1};
						end
					end
				end else if (pos_q == chk_pos) begin
					sumhi_d = byte_s1;
				end else begin
					// last checksum byte: report and go back to hunting
					res_valid       = 1'b1;
					res.is_status   = 1'b1;
					res.checksum_ok = ({sumhi_q, byte_s1} == sum_q);
					in_pkt_d        = 1'b0;
					pos_d           = '0;
					sum_d           = '0;
					shift_d         = '0;
					sumhi_d         = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
			sum_q    <= '0;
			shift_q  <= '0;
			sumhi_q  <= '0;
		end else if (cfg_clear) begin
			in_pkt_q <= 1'b0;
			pos_q    <= '0;
			sum_q    <= '0;
			shift_q  <= '0;
			sumhi_q  <= '0;
		end else begin
			in_pkt_q <= in_pkt_d;
			pos_q    <= pos_d;
			sum_q    <= sum_d;
			shift_q  <= shift_d;
			sumhi_q  <= sumhi_d;
		end
	end

endmodule

`default_nettype wire

### rtl/idf_out_buf.sv
// Two-entry result buffer that decouples the framer from the result channel.
`default_nettype none

module idf_out_buf import idf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	idf_result_if.source res,
	output logic [1:0]   avail
);

	result_t    entry_q [OB_DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	result_t    head;

	assign pop  = res.valid && res.ready;
	assign head = entry_q[rd_ptr_q];

	// Free slots counting the entry leaving this cycle
	assign avail = 2'(OB_DEPTH) - cnt_q + {1'b0, pop};

	assign res.valid       = cnt_q != 2'd0;
	assign res.word_value  = head.word_value;
	assign res.word_index  = head.word_index;
	assign res.is_status   = head.is_status;
	assign res.checksum_ok = head.checksum_ok;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

`default_nettype wire

### rtl/imu_packet_deframer.sv
// Top level of the IMU packet deframer: one serial byte in, data words and status out.
// Path: the byte that completes a result is held in the byte register, and the result is
// then written to the result buffer, which drives res.valid.
// Throughput: one byte per cycle, set by the single-pass framer between the input byte
// register and the two-entry result buffer; ready drops only when that buffer backs up.
// Reset (arst_n low, asynchronous): mode 0, framer hunting, buffer empty.
`default_nettype none

module imu_packet_deframer import idf_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	idf_byte_if.sink                   rx,
	idf_result_if.source               res
);

	mode_t      mode;
	logic       cfg_clear;
	logic [1:0] buf_avail;
	logic       fr_valid;
	result_t    fr_res;

	// Mode register; a write drops any partial packet
	idf_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.mode      (mode),
		.cfg_clear (cfg_clear)
	);

	// Header hunt, word assembly, sum16 and checksum compare, one byte a cycle while the result buffer has room
	idf_framer u_framer (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.mode      (mode),
		.cfg_clear (cfg_clear),
		.buf_avail (buf_avail),
		.res_valid (fr_valid),
		.res       (fr_res)
	);

	// Result registers; bytes keep flowing while a result waits downstream
	idf_out_buf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (fr_valid),
		.push_data (fr_res),
		.res       (res),
		.avail     (buf_avail)
	);

endmodule

`default_nettype wire
